[sv/ipl4_pkg.sv]
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
package ipl4_pkg;

  // Default saturation point of the frame byte counter.
  localparam int unsigned MAX_FRAME_BYTES = 2048;

  // Depth of the record queue between the capture front and the classify back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Length thresholds: end of each header, in bytes from the frame start.
  localparam int unsigned ETH_HDR_END = 14;
  localparam int unsigned IP_HDR_END  = 34;
  localparam int unsigned UDP_HDR_END = 42;
  localparam int unsigned TCP_HDR_END = 54;

  // Summary status codes.
  typedef enum logic [2:0] {
    ST_ETH_SHORT = 3'd0,
    ST_NON_IP    = 3'd1,
    ST_IP_SHORT  = 3'd2,
    ST_OTHER     = 3'd3,
    ST_UDP_SHORT = 3'd4,
    ST_TCP_SHORT = 3'd5,
    ST_UDP_OK    = 3'd6,
    ST_TCP_OK    = 3'd7
  } status_e;

  // One input item: a frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result item: the frame summary.
  typedef struct packed {
    status_e     status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [7:0]  ip_proto;
    logic [15:0] ip_total_length;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] tcp_sequence;
    logic [11:0] payload_length;
  } res_t;

  // Length flags, each true when the frame ends before that header ends.
  typedef struct packed {
    logic lt_eth;
    logic lt_ip;
    logic lt_udp;
    logic lt_tcp;
  } len_flags_t;

  // Frame record handed from the front to the back.
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [15:0] ip_length;
    logic [7:0]  ip_proto;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [31:0] port_pair;
    logic [31:0] tcp_sequence;
    logic [11:0] len_low;
    len_flags_t  flags;
  } rec_t;

endpackage

[sv/ipl4_front.sv]
// Capture front: counts frame bytes, places header bytes and emits a record per frame.
module ipl4_front #(
  parameter int unsigned MaxFrameBytes = ipl4_pkg::MAX_FRAME_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipl4_pkg::in_t  data_i,
  input  logic           push_i,
  output logic           full_o,
  output ipl4_pkg::rec_t rec_o,
  output logic           rec_push_o,
  input  logic           rec_full_i
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    len_n;
  logic [CntW+11:0]   len_ext;
  logic               accept;
  ipl4_pkg::rec_t     fld_q, fld_d;

  // The front stalls only when the record queue has no room.
  assign full_o = rec_full_i;
  assign accept = push_i & ~rec_full_i;

  // Saturating byte count including the current item.
  assign len_n   = (cnt_q < CntW'(MaxFrameBytes)) ? cnt_q + CntW'(1) : cnt_q;
  assign len_ext = (CntW + 12)'(len_n);

  // Place the current byte at its offset in the header fields.
  always_comb begin
    fld_d = fld_q;
    for (int k = 0; k < 6; k++) begin
      if (cnt_q == CntW'(k)) fld_d.dst_mac[8*(5-k) +: 8] = data_i.data_byte;
      if (cnt_q == CntW'(k + 6)) fld_d.src_mac[8*(5-k) +: 8] = data_i.data_byte;
    end
    for (int k = 0; k < 2; k++) begin
      if (cnt_q == CntW'(k + 12)) fld_d.ether_type[8*(1-k) +: 8] = data_i.data_byte;
      if (cnt_q == CntW'(k + 16)) fld_d.ip_length[8*(1-k) +: 8] = data_i.data_byte;
    end
    if (cnt_q == CntW'(23)) fld_d.ip_proto = data_i.data_byte;
    for (int k = 0; k < 4; k++) begin
      if (cnt_q == CntW'(k + 26)) fld_d.ip_source[8*(3-k) +: 8] = data_i.data_byte;
      if (cnt_q == CntW'(k + 30)) fld_d.ip_dest[8*(3-k) +: 8] = data_i.data_byte;
      if (cnt_q == CntW'(k + 34)) fld_d.port_pair[8*(3-k) +: 8] = data_i.data_byte;
      if (cnt_q == CntW'(k + 38)) fld_d.tcp_sequence[8*(3-k) +: 8] = data_i.data_byte;
    end
    // Length classification of the frame as it would end on this byte.
    fld_d.len_low      = len_ext[11:0];
    fld_d.flags.lt_eth = len_n < CntW'(ipl4_pkg::ETH_HDR_END);
    fld_d.flags.lt_ip  = len_n < CntW'(ipl4_pkg::IP_HDR_END);
    fld_d.flags.lt_udp = len_n < CntW'(ipl4_pkg::UDP_HDR_END);
    fld_d.flags.lt_tcp = len_n < CntW'(ipl4_pkg::TCP_HDR_END);
  end

  // Counter restarts after the last byte of a frame.
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = data_i.last_byte ? '0 : len_n;
    end
  end

  assign rec_o      = fld_d;
  assign rec_push_o = accept & data_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Header fields are not reset; offsets past a short frame's end keep the previous frame's bytes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fld_q <= fld_d;
    end
  end

endmodule

[sv/ipl4_queue.sv]
// Short record queue between the capture front and the classify back.
module ipl4_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipl4_pkg::rec_t wr_rec_i,
  input  logic           wr_en_i,
  output logic           full_o,
  output ipl4_pkg::rec_t rd_rec_o,
  input  logic           rd_en_i,
  output logic           empty_o
);

  localparam int unsigned Depth = ipl4_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ipl4_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o   = cnt_q == CntW'(Depth);
  assign empty_o  = cnt_q == '0;
  assign do_wr    = wr_en_i & ~full_o;
  assign do_rd    = rd_en_i & ~empty_o;
  assign rd_rec_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

endmodule

[sv/ipl4_back.sv]
// Classify back: decides the frame status, masks unreached fields and holds the result item.
module ipl4_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipl4_pkg::rec_t rec_i,
  input  logic           rec_empty_i,
  output logic           rec_pop_o,
  output ipl4_pkg::res_t res_o,
  output logic           empty_o,
  input  logic           pop_i
);

  ipl4_pkg::status_e st;
  ipl4_pkg::res_t    res_q, res_d;
  logic              valid_q, valid_d;
  logic              load;

  // Status from the length flags and the captured type and protocol.
  always_comb begin
    priority if (rec_i.flags.lt_eth) begin
      st = ipl4_pkg::ST_ETH_SHORT;
    end else if (rec_i.ether_type != ipl4_pkg::ETHERTYPE_IPV4) begin
      st = ipl4_pkg::ST_NON_IP;
    end else if (rec_i.flags.lt_ip) begin
      st = ipl4_pkg::ST_IP_SHORT;
    end else if (rec_i.ip_proto == ipl4_pkg::PROTO_UDP) begin
      st = rec_i.flags.lt_udp ? ipl4_pkg::ST_UDP_SHORT : ipl4_pkg::ST_UDP_OK;
    end else if (rec_i.ip_proto == ipl4_pkg::PROTO_TCP) begin
      st = rec_i.flags.lt_tcp ? ipl4_pkg::ST_TCP_SHORT : ipl4_pkg::ST_TCP_OK;
    end else begin
      st = ipl4_pkg::ST_OTHER;
    end
  end

  // Build the summary, giving zero for every field the status does not cover.
  always_comb begin
    res_d        = '0;
    res_d.status = st;
    if (st != ipl4_pkg::ST_ETH_SHORT) begin
      res_d.dst_mac    = rec_i.dst_mac;
      res_d.src_mac    = rec_i.src_mac;
      res_d.ether_type = rec_i.ether_type;
    end
    if (st != ipl4_pkg::ST_ETH_SHORT && st != ipl4_pkg::ST_NON_IP &&
        st != ipl4_pkg::ST_IP_SHORT) begin
      res_d.ip_source       = rec_i.ip_source;
      res_d.ip_dest         = rec_i.ip_dest;
      res_d.ip_proto        = rec_i.ip_proto;
      res_d.ip_total_length = rec_i.ip_length;
    end
    if (st == ipl4_pkg::ST_UDP_OK) begin
      res_d.source_port    = rec_i.port_pair[31:16];
      res_d.dest_port      = rec_i.port_pair[15:0];
      res_d.payload_length = rec_i.len_low - 12'(ipl4_pkg::UDP_HDR_END);
    end
    if (st == ipl4_pkg::ST_TCP_OK) begin
      res_d.source_port    = rec_i.port_pair[31:16];
      res_d.dest_port      = rec_i.port_pair[15:0];
      res_d.tcp_sequence   = rec_i.tcp_sequence;
      res_d.payload_length = rec_i.len_low - 12'(ipl4_pkg::TCP_HDR_END);
    end
  end

  // Output register refills in the same cycle its item is taken, if the queue holds a record.
  assign load      = ~rec_empty_i & (~valid_q | pop_i);
  assign rec_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o   = res_q;
  assign empty_o = ~valid_q;

endmodule

[sv/eth_ipv4_l4_header_parser.sv]
// Top level of the Ethernet/IPv4/UDP-TCP header parser.
//
//   Channel   Ports                    Direction  Item
//   bytes     push_i, full_o, data_i   in         one frame byte with last flag
//   summary   pop_i, empty_o, res_o    out        one summary per frame
//
// One byte is taken every cycle while full_o is low; full_o rises only when the
// two-entry record queue is full because the summary output is not being popped.
// A summary reaches res_o after its last byte is taken: that byte's edge writes the
// record queue, then the classify register loads it once empty or being popped.
// Reset clears the byte counter, the queue and the output valid; no clearing pass.
// Summaries stall independently of the byte side until the queue fills.
module eth_ipv4_l4_header_parser #(
  parameter int unsigned MaxFrameBytes = ipl4_pkg::MAX_FRAME_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipl4_pkg::in_t  data_i,
  input  logic           push_i,
  output logic           full_o,
  output ipl4_pkg::res_t res_o,
  output logic           empty_o,
  input  logic           pop_i
);

  ipl4_pkg::rec_t rec_in, rec_out;
  logic           rec_push, rec_full, rec_pop, rec_empty;

  // Byte capture and length classification.
  ipl4_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_i     (data_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .rec_o      (rec_in),
    .rec_push_o (rec_push),
    .rec_full_i (rec_full)
  );

  // Record queue.
  ipl4_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_rec_i (rec_in),
    .wr_en_i  (rec_push),
    .full_o   (rec_full),
    .rd_rec_o (rec_out),
    .rd_en_i  (rec_pop),
    .empty_o  (rec_empty)
  );

  // Status decision and output register.
  ipl4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .res_o       (res_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

  // The front never writes a record into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rec_push |-> !rec_full)
    else $error("record written into a full queue");

  // A taken last byte leaves a record waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && data_i.last_byte) |=> !rec_empty)
    else $error("frame end produced no record");

  // Port and payload fields are zero unless a UDP or TCP header was parsed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.status != ipl4_pkg::ST_UDP_OK &&
     res_o.status != ipl4_pkg::ST_TCP_OK) |->
    (res_o.source_port == '0 && res_o.dest_port == '0 && res_o.payload_length == '0))
    else $error("port fields set without a parsed transport header");

  // The TCP sequence is reported only for a parsed TCP header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.status != ipl4_pkg::ST_TCP_OK) |-> res_o.tcp_sequence == '0)
    else $error("sequence number set without a parsed TCP header");

endmodule
